[hw/rtl/gif_lzw_encoder_assert.svh]
// Assertion macros for the GIF LZW encoder checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef GIF_LZW_ENCODER_ASSERT_SVH
`define GIF_LZW_ENCODER_ASSERT_SVH

// Consequent checked on the next clock.
`define GLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent checked on the same clock.
`define GLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[hw/rtl/gle_pkg.sv]
// Shared types and constants of the GIF LZW encoder.
// No dependencies.
package gle_pkg;

	localparam int unsigned DEF_TABLE_ENTRIES = 4096;
	localparam int unsigned DEF_MAX_CODE_BITS = 12;

	localparam int unsigned LINK_W    = 13;
	localparam int unsigned SYM_W     = 8;
	localparam int unsigned CFG_W     = 4;
	localparam int unsigned CW_W      = 4;
	localparam int unsigned CODE_W    = 13;
	localparam int unsigned BUF_W     = 20;
	localparam int unsigned CNT_W     = 5;
	localparam int unsigned ROOT_SLOTS = 256;
	localparam int unsigned ROOT_AW   = 8;

	localparam logic [LINK_W-1:0] NONE_LINK = '1;
	localparam logic [CFG_W-1:0]  COLOR_MIN = 4'd2;
	localparam logic [CFG_W-1:0]  COLOR_MAX = 4'd8;
	localparam logic [CFG_W-1:0]  COLOR_RESET = 4'd8;

	typedef enum logic [1:0] {
		PUT_NONE,
		PUT_PREFIX,
		PUT_CLEAR,
		PUT_END
	} put_sel_t;

	typedef struct packed {
		logic     accept;
		logic     frame_init;
		logic     rd_fc;
		logic     rd_from_fc;
		logic     rd_from_sib;
		logic     wr_new;
		logic     wr_link;
		logic     link_child;
		put_sel_t put_sel;
		logic     drain;
		logic     final_mode;
		logic     take_found;
		logic     tbl_update;
		logic     frame_done;
	} gle_cmd_t;

	typedef struct packed {
		logic in_frame;
		logic last;
		logic link_none;
		logic sym_match;
		logic sib_none;
		logic nf_ok;
		logic need_clear;
		logic full_byte;
		logic any_bits;
	} gle_status_t;

endpackage

[hw/rtl/gif_lzw_encoder.sv]
// Top level of the GIF LZW encoder: controller plus datapath.
// Depends on gle_pkg, gle_ctrl, gle_dpath.
//
// channel  | direction | transaction
// s_axis   | in        | one pixel: tdata pixel_index, tlast last_pixel
// m_axis   | out       | one packed code byte: tdata code_byte, tlast frame_end
// cfg      | in        | color_bits write, taken at any time, used at frame start
//
// The trie walk reads one sibling per cycle, so the time for one pixel grows with
// the length of the sibling chain that it searches (up to 256 entries).
// Output bytes go out from the drain step while m_axis is not stalled.
// A stalled m_axis holds the controller in its drain step; s_axis waits.
// Reset needs no clearing pass: root links are covered by 256 valid bits.
module gif_lzw_encoder #(
	parameter int unsigned TABLE_ENTRIES = gle_pkg::DEF_TABLE_ENTRIES,
	parameter int unsigned MAX_CODE_BITS = gle_pkg::DEF_MAX_CODE_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] pixel_index
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] code_byte
	output logic       m_axis_tlast,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data
);
	gle_pkg::gle_cmd_t    cmd;
	gle_pkg::gle_status_t sts;

	assign cfg_ready = 1'b1;

	gle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gle_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.pixel_index (s_axis_tdata),
		.last_pixel  (s_axis_tlast),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (m_axis_tdata),
		.out_last    (m_axis_tlast)
	);

endmodule

[hw/rtl/gle_dpath.sv]
// Datapath: trie memories, code counters, bit packer and output register.
// Depends on gle_pkg; driven by gle_ctrl.
module gle_dpath #(
	parameter int unsigned TABLE_ENTRIES = gle_pkg::DEF_TABLE_ENTRIES,
	parameter int unsigned MAX_CODE_BITS = gle_pkg::DEF_MAX_CODE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gle_pkg::gle_cmd_t          cmd,
	output gle_pkg::gle_status_t       sts,
	input  logic [7:0]                 pixel_index,
	input  logic                       last_pixel,
	input  logic                       cfg_valid,
	input  logic [gle_pkg::CFG_W-1:0]  cfg_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 out_byte,
	output logic                       out_last
);
	localparam int unsigned AW = $clog2(TABLE_ENTRIES);
	localparam int unsigned NW = AW + 1;

	logic [gle_pkg::SYM_W-1:0]  sym_mem [TABLE_ENTRIES];
	logic [gle_pkg::LINK_W-1:0] fc_mem  [TABLE_ENTRIES];
	logic [gle_pkg::LINK_W-1:0] sib_mem [TABLE_ENTRIES];

	logic [gle_pkg::CFG_W-1:0]  cfg_q;
	logic [gle_pkg::CFG_W-1:0]  fb_q;
	logic [7:0]                 pix_q;
	logic                       last_q;
	logic                       in_frame_q;
	logic [AW-1:0]              prefix_q;
	logic [AW-1:0]              cur_q;
	logic [NW-1:0]              nf_q;
	logic [gle_pkg::CW_W-1:0]   cw_q;
	logic [gle_pkg::BUF_W-1:0]  buf_q;
	logic [gle_pkg::CNT_W-1:0]  cnt_q;
	logic [gle_pkg::ROOT_SLOTS-1:0] valid_q;
	logic [gle_pkg::LINK_W-1:0] fc_rd_q;
	logic                       fc_ok_q;
	logic [gle_pkg::SYM_W-1:0]  sym_rd_q;
	logic [gle_pkg::LINK_W-1:0] sib_rd_q;
	logic                       ov_q;
	logic [7:0]                 od_q;
	logic                       ol_q;

	logic [gle_pkg::CFG_W-1:0]  fb_next;
	logic [gle_pkg::CODE_W-1:0] clr_code;
	logic [gle_pkg::CODE_W-1:0] put_code;
	logic [gle_pkg::CODE_W-1:0] cw_mask;
	logic [7:0]                 sym_w;
	logic [7:0]                 init_mask;
	logic [gle_pkg::LINK_W-1:0] link;
	logic [AW-1:0]              rd_addr;
	logic                       rd_en;
	logic                       nf_ok;
	logic                       nf_over;
	logic                       need_clear;
	logic                       full_byte;
	logic                       any_bits;
	logic                       emit;
	logic [gle_pkg::CNT_W-1:0]  cnt_after;
	logic                       prefix_root;
	logic                       nf_root;
	logic                       sib_we;
	logic [AW-1:0]              sib_wa;
	logic [gle_pkg::LINK_W-1:0] sib_wd;
	logic                       fc_we;
	logic [AW-1:0]              fc_wa;
	logic [gle_pkg::LINK_W-1:0] fc_wd;

	always_comb begin
		if (cfg_q < gle_pkg::COLOR_MIN) begin
			fb_next = gle_pkg::COLOR_MIN;
		end else if (cfg_q > gle_pkg::COLOR_MAX) begin
			fb_next = gle_pkg::COLOR_MAX;
		end else begin
			fb_next = cfg_q;
		end
	end

	assign init_mask = 8'((9'd1 << fb_next) - 9'd1);
	assign sym_w     = pix_q & 8'((9'd1 << fb_q) - 9'd1);
	assign clr_code  = gle_pkg::CODE_W'(1) << fb_q;
	assign cw_mask   = gle_pkg::CODE_W'((gle_pkg::CODE_W'(1) << cw_q) - gle_pkg::CODE_W'(1));
	assign link      = fc_ok_q ? fc_rd_q : gle_pkg::NONE_LINK;
	assign nf_ok     = nf_q < NW'(TABLE_ENTRIES);
	assign nf_over   = (nf_q >> cw_q) != '0;
	assign need_clear = !nf_ok || (nf_over && (cw_q >= gle_pkg::CW_W'(MAX_CODE_BITS)));
	assign full_byte = cnt_q >= gle_pkg::CNT_W'(8);
	assign any_bits  = cnt_q != '0;
	assign emit      = cmd.drain && (!ov_q || out_ready)
	                   && (cmd.final_mode ? any_bits : full_byte);
	assign cnt_after = full_byte ? cnt_q - gle_pkg::CNT_W'(8) : '0;
	assign prefix_root = prefix_q < AW'(gle_pkg::ROOT_SLOTS);
	assign nf_root   = nf_q < NW'(gle_pkg::ROOT_SLOTS);

	always_comb begin
		case (cmd.put_sel)
			gle_pkg::PUT_PREFIX: put_code = gle_pkg::CODE_W'(prefix_q);
			gle_pkg::PUT_CLEAR:  put_code = clr_code;
			gle_pkg::PUT_END:    put_code = clr_code + gle_pkg::CODE_W'(1);
			default:             put_code = '0;
		endcase
	end

	assign rd_en   = cmd.rd_from_fc || cmd.rd_from_sib;
	assign rd_addr = cmd.rd_from_fc ? link[AW-1:0] : sib_rd_q[AW-1:0];

	always_comb begin
		sib_we = 1'b0;
		sib_wa = nf_q[AW-1:0];
		sib_wd = gle_pkg::NONE_LINK;
		fc_we  = 1'b0;
		fc_wa  = nf_q[AW-1:0];
		fc_wd  = gle_pkg::NONE_LINK;
		if (cmd.wr_new) begin
			sib_we = 1'b1;
			fc_we  = 1'b1;
		end else if (cmd.wr_link) begin
			if (cmd.link_child) begin
				fc_we = 1'b1;
				fc_wa = prefix_q;
				fc_wd = gle_pkg::LINK_W'(nf_q);
			end else begin
				sib_we = 1'b1;
				sib_wa = cur_q;
				sib_wd = gle_pkg::LINK_W'(nf_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_new) begin
			sym_mem[nf_q[AW-1:0]] <= sym_w;
		end
		if (sib_we) begin
			sib_mem[sib_wa] <= sib_wd;
		end
		if (fc_we) begin
			fc_mem[fc_wa] <= fc_wd;
		end
		if (cmd.rd_fc) begin
			fc_rd_q <= fc_mem[prefix_q];
			fc_ok_q <= !prefix_root || valid_q[prefix_q[gle_pkg::ROOT_AW-1:0]];
		end
		if (rd_en) begin
			sym_rd_q <= sym_mem[rd_addr];
			sib_rd_q <= sib_mem[rd_addr];
			cur_q    <= rd_addr;
		end
		if (cmd.accept) begin
			pix_q  <= pixel_index;
			last_q <= last_pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= gle_pkg::COLOR_RESET;
			fb_q       <= gle_pkg::COLOR_RESET;
			in_frame_q <= 1'b0;
			prefix_q   <= '0;
			nf_q       <= NW'(258);
			cw_q       <= gle_pkg::CW_W'(9);
			buf_q      <= '0;
			cnt_q      <= '0;
			valid_q    <= '0;
			ov_q       <= 1'b0;
			od_q       <= '0;
			ol_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cfg_q <= cfg_data;
			end
			if (cmd.frame_init) begin
				fb_q       <= fb_next;
				nf_q       <= NW'(gle_pkg::CODE_W'(1) << fb_next) + NW'(2);
				cw_q       <= gle_pkg::CW_W'(fb_next) + gle_pkg::CW_W'(1);
				buf_q      <= '0;
				cnt_q      <= '0;
				valid_q    <= '0;
				prefix_q   <= AW'(pix_q & init_mask);
				in_frame_q <= 1'b1;
			end
			if (cmd.wr_new && nf_root) begin
				valid_q[nf_q[gle_pkg::ROOT_AW-1:0]] <= 1'b1;
			end
			if (cmd.wr_link && cmd.link_child && prefix_root) begin
				valid_q[prefix_q[gle_pkg::ROOT_AW-1:0]] <= 1'b1;
			end
			if (cmd.take_found) begin
				prefix_q <= cur_q;
			end
			if (cmd.tbl_update) begin
				prefix_q <= AW'(sym_w);
				if (need_clear) begin
					nf_q    <= NW'(clr_code) + NW'(2);
					cw_q    <= gle_pkg::CW_W'(fb_q) + gle_pkg::CW_W'(1);
					valid_q <= '0;
				end else begin
					if (nf_over) begin
						cw_q <= cw_q + gle_pkg::CW_W'(1);
					end
					nf_q <= nf_q + NW'(1);
				end
			end
			if (cmd.put_sel != gle_pkg::PUT_NONE) begin
				buf_q <= buf_q | (gle_pkg::BUF_W'(put_code & cw_mask) << cnt_q);
				cnt_q <= cnt_q + gle_pkg::CNT_W'(cw_q);
			end
			if (emit) begin
				od_q  <= buf_q[7:0];
				ol_q  <= cmd.final_mode && (cnt_after == '0);
				ov_q  <= 1'b1;
				buf_q <= buf_q >> 8;
				cnt_q <= cnt_after;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			if (cmd.frame_done) begin
				in_frame_q <= 1'b0;
				buf_q      <= '0;
				cnt_q      <= '0;
			end
		end
	end

	assign sts.in_frame   = in_frame_q;
	assign sts.last       = last_q;
	assign sts.link_none  = link >= gle_pkg::LINK_W'(TABLE_ENTRIES);
	assign sts.sym_match  = sym_rd_q == sym_w;
	assign sts.sib_none   = sib_rd_q >= gle_pkg::LINK_W'(TABLE_ENTRIES);
	assign sts.nf_ok      = nf_ok;
	assign sts.need_clear = need_clear;
	assign sts.full_byte  = full_byte;
	assign sts.any_bits   = any_bits;

	assign out_valid = ov_q;
	assign out_byte  = od_q;
	assign out_last  = ol_q;

endmodule

[hw/rtl/gle_ctrl.sv]
// Controller: sequences lookup, table update and code output per pixel, and the flush at frame end.
// Depends on gle_pkg; drives gle_dpath.
module gle_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  gle_pkg::gle_status_t sts,
	output gle_pkg::gle_cmd_t    cmd
);
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_PUT_CLR,
		ST_DRAIN,
		ST_POST,
		ST_FC_RD,
		ST_FC_CHK,
		ST_WALK,
		ST_FOUND,
		ST_NEW_ENT,
		ST_NEW_LINK,
		ST_PUT_PFX,
		ST_CHK_CLR,
		ST_UPDATE,
		ST_FIN_PFX,
		ST_FIN_END
	} state_t;

	state_t state_q;
	state_t ret_q;
	logic   child_q;
	logic   final_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.put_sel = gle_pkg::PUT_NONE;
		cmd.link_child = child_q;
		cmd.final_mode = final_q;
		case (state_q)
			ST_IDLE:     cmd.accept = in_valid;
			ST_INIT:     cmd.frame_init = 1'b1;
			ST_PUT_CLR:  cmd.put_sel = gle_pkg::PUT_CLEAR;
			ST_DRAIN: begin
				cmd.drain = 1'b1;
				cmd.frame_done = final_q && !sts.any_bits;
			end
			ST_FC_RD:    cmd.rd_fc = 1'b1;
			ST_FC_CHK:   cmd.rd_from_fc = !sts.link_none;
			ST_WALK:     cmd.rd_from_sib = !sts.sym_match && !sts.sib_none;
			ST_FOUND:    cmd.take_found = 1'b1;
			ST_NEW_ENT:  cmd.wr_new = sts.nf_ok;
			ST_NEW_LINK: cmd.wr_link = 1'b1;
			ST_PUT_PFX:  cmd.put_sel = gle_pkg::PUT_PREFIX;
			ST_UPDATE:   cmd.tbl_update = 1'b1;
			ST_FIN_PFX:  cmd.put_sel = gle_pkg::PUT_PREFIX;
			ST_FIN_END:  cmd.put_sel = gle_pkg::PUT_END;
			default:     cmd.accept = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			child_q <= 1'b0;
			final_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= sts.in_frame ? ST_FC_RD : ST_INIT;
					end
				end
				ST_INIT: begin
					ret_q   <= ST_POST;
					state_q <= ST_PUT_CLR;
				end
				ST_PUT_CLR: state_q <= ST_DRAIN;
				ST_DRAIN: begin
					if (!(final_q ? sts.any_bits : sts.full_byte)) begin
						state_q <= ret_q;
						if (final_q) begin
							final_q <= 1'b0;
						end
					end
				end
				ST_POST:   state_q <= sts.last ? ST_FIN_PFX : ST_IDLE;
				ST_FC_RD:  state_q <= ST_FC_CHK;
				ST_FC_CHK: begin
					if (sts.link_none) begin
						child_q <= 1'b1;
						state_q <= ST_NEW_ENT;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (sts.sym_match) begin
						state_q <= ST_FOUND;
					end else if (sts.sib_none) begin
						child_q <= 1'b0;
						state_q <= ST_NEW_ENT;
					end
				end
				ST_FOUND:    state_q <= ST_POST;
				ST_NEW_ENT:  state_q <= sts.nf_ok ? ST_NEW_LINK : ST_PUT_PFX;
				ST_NEW_LINK: state_q <= ST_PUT_PFX;
				ST_PUT_PFX: begin
					ret_q   <= ST_CHK_CLR;
					state_q <= ST_DRAIN;
				end
				ST_CHK_CLR: begin
					ret_q   <= ST_UPDATE;
					state_q <= sts.need_clear ? ST_PUT_CLR : ST_UPDATE;
				end
				ST_UPDATE: state_q <= ST_POST;
				ST_FIN_PFX: begin
					ret_q   <= ST_FIN_END;
					state_q <= ST_DRAIN;
				end
				ST_FIN_END: begin
					final_q <= 1'b1;
					ret_q   <= ST_IDLE;
					state_q <= ST_DRAIN;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/gle_checker.sv]
// Port-level checks of the GIF LZW encoder, bound to the top level.
// Depends on gif_lzw_encoder_assert.svh.
`include "gif_lzw_encoder_assert.svh"

module gle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic [3:0] cfg_data
);
	`GLE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")
	`GLE_ASSERT_NEXT(a_one_pixel, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second pixel taken before work done")
	`GLE_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready, "config write refused")

endmodule

bind gif_lzw_encoder gle_checker u_gle_checker (.*);
